[sv/drl_pkg.sv]
package drl_pkg;

    localparam int COORD_W = 12;
    localparam int IDX_W   = 8;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_FULL  = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
    } t_rect;

    typedef struct packed {
        logic             valid;
        logic [1:0]       mode;
        logic             done;
        logic [IDX_W-1:0] idx;
        t_rect            rect;
        logic             flag;
    } t_beat;

    function automatic logic rect_zero(input t_rect r);
        return (r.x1 == '0) && (r.y1 == '0) && (r.x2 == '0) && (r.y2 == '0);
    endfunction

endpackage

[sv/drl_cell.sv]
module drl_cell #(
    parameter int IDX    = 0,
    parameter int SCR_W  = 640,
    parameter int SCR_H  = 480
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  drl_pkg::t_beat i_beat,
    output drl_pkg::t_beat o_beat
);
    import drl_pkg::*;

    localparam logic [IDX_W-1:0]   MY_IDX = IDX_W'(IDX);
    localparam logic [COORD_W-1:0] W_C    = COORD_W'(SCR_W);
    localparam logic [COORD_W-1:0] H_C    = COORD_W'(SCR_H);

    t_rect r_slot, n_slot;
    logic  r_always, n_always;
    t_beat r_beat, n_beat;
    logic  overlap;

    assign overlap = (r_slot.x2 >= i_beat.rect.x1) && (r_slot.x1 < i_beat.rect.x2) &&
                     (r_slot.y2 >= i_beat.rect.y1) && (r_slot.y1 < i_beat.rect.y2);

    always_comb begin
        n_slot   = r_slot;
        n_always = r_always;
        n_beat   = i_beat;
        if (i_beat.valid) begin
            case (i_beat.mode)
                MODE_ADD: begin
                    if (!i_beat.done) begin
                        if (rect_zero(r_slot)) begin
                            n_slot      = i_beat.rect;
                            n_always    = i_beat.flag;
                            n_beat.done = 1'b1;
                        end else if (overlap) begin
                            if (i_beat.rect.x1 < r_slot.x1) n_slot.x1 = i_beat.rect.x1;
                            if (i_beat.rect.y1 < r_slot.y1) n_slot.y1 = i_beat.rect.y1;
                            if (i_beat.rect.x2 > r_slot.x2) n_slot.x2 = i_beat.rect.x2;
                            if (i_beat.rect.y2 > r_slot.y2) n_slot.y2 = i_beat.rect.y2;
                            n_always    = r_always | i_beat.flag;
                            n_beat.done = 1'b1;
                        end
                    end
                end
                MODE_CLEAR: begin
                    n_slot   = '0;
                    n_always = 1'b0;
                end
                MODE_FULL: begin
                    n_slot   = '0;
                    n_always = 1'b0;
                    if (IDX == 0) begin
                        n_slot.x2 = W_C;
                        n_slot.y2 = H_C;
                        n_always  = 1'b1;
                    end
                end
                MODE_READ: begin
                    if (i_beat.idx == MY_IDX) begin
                        n_beat.rect = r_slot;
                        n_beat.flag = r_always;
                        n_beat.done = 1'b1;
                    end
                end
                default: begin
                    n_beat = i_beat;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot       <= '0;
            r_always     <= 1'b0;
            r_beat.valid <= 1'b0;
        end else begin
            r_slot       <= n_slot;
            r_always     <= n_always;
            r_beat.valid <= n_beat.valid;
        end
        r_beat.mode <= n_beat.mode;
        r_beat.done <= n_beat.done;
        r_beat.idx  <= n_beat.idx;
        r_beat.rect <= n_beat.rect;
        r_beat.flag <= n_beat.flag;
    end

    assign o_beat = r_beat;

endmodule

[sv/dirty_region_list_core.sv]
// dirty region table: a row of MAX_REGIONS cells, one slot each
// input: a command beat is taken on a clock edge with start high and busy low;
//   i_mode selects add (clip then merge or insert), clear, clear with full
//   screen mark, or read of slot i_slot_index
// output: o_valid is high for exactly one cycle with the result beat on
//   o_status and the o_read_* ports; the receiver cannot hold it off
// every command walks the row one cell per cycle, registered first in the head
//   register and then in each cell, and the result leaves the last cell
// busy stays high until the result cycle has passed, so a new command is taken
//   only after the previous one has left the row
// clear commands wipe each slot as the beat passes its cell; later commands
//   follow behind and see the cleared slots
// status is 1 only for an add that found no free or overlapping slot
// read fields are zero for every mode but read, and for a slot out of range
// reset: synchronous, active low; empties every slot and drops any beat in flight
module dirty_region_list_core #(
    parameter int MAX_REGIONS   = 32,
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_x_left,
    input  logic [15:0] i_y_top,
    input  logic [15:0] i_x_right,
    input  logic [15:0] i_y_bottom,
    input  logic        i_always_redraw,
    input  logic [4:0]  i_slot_index,
    output logic        o_valid,
    output logic        o_status,
    output logic [11:0] o_read_x_left,
    output logic [11:0] o_read_y_top,
    output logic [11:0] o_read_x_right,
    output logic [11:0] o_read_y_bottom,
    output logic        o_read_always,
    output logic        o_read_used
);
    import drl_pkg::*;

    localparam logic signed [15:0] W_S = 16'(SCREEN_WIDTH);
    localparam logic signed [15:0] H_S = 16'(SCREEN_HEIGHT);

    logic               accept;
    logic               r_busy, n_busy;
    t_beat              r_head, n_head;
    t_beat              w_beat [0:MAX_REGIONS];
    t_beat              last;
    logic signed [15:0] l, t, r, b, cx1, cy1, cx2, cy2;
    logic               empty;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    assign l = i_x_left;
    assign t = i_y_top;
    assign r = i_x_right;
    assign b = i_y_bottom;

    always_comb begin
        cx1   = (l > 16'sd0) ? l : 16'sd0;
        cy1   = (t > 16'sd0) ? t : 16'sd0;
        cx2   = (r < W_S) ? r : W_S;
        cy2   = (b < H_S) ? b : H_S;
        empty = (cx1 >= cx2) || (cy1 >= cy2);

        n_head       = '0;
        n_head.valid = accept;
        n_head.mode  = i_mode;
        n_head.idx   = IDX_W'(i_slot_index);
        if (i_mode == MODE_ADD) begin
            n_head.flag = i_always_redraw;
            if (!empty) begin
                n_head.rect.x1 = cx1[COORD_W-1:0];
                n_head.rect.y1 = cy1[COORD_W-1:0];
                n_head.rect.x2 = cx2[COORD_W-1:0];
                n_head.rect.y2 = cy2[COORD_W-1:0];
            end
        end
    end

    assign last = w_beat[MAX_REGIONS];

    always_comb begin
        n_busy = r_busy;
        if (last.valid) begin
            n_busy = 1'b0;
        end else if (accept) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_head.valid <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_head.valid <= n_head.valid;
        end
        r_head.mode <= n_head.mode;
        r_head.done <= n_head.done;
        r_head.idx  <= n_head.idx;
        r_head.rect <= n_head.rect;
        r_head.flag <= n_head.flag;
    end

    assign w_beat[0] = r_head;

    for (genvar gi = 0; gi < MAX_REGIONS; gi++) begin : g_cell
        drl_cell #(
            .IDX   (gi),
            .SCR_W (SCREEN_WIDTH),
            .SCR_H (SCREEN_HEIGHT)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_beat[gi]),
            .o_beat  (w_beat[gi+1])
        );
    end

    logic is_read;
    assign is_read = (last.mode == MODE_READ);

    assign o_valid         = last.valid;
    assign o_status        = (last.mode == MODE_ADD) && !last.done;
    assign o_read_x_left   = is_read ? last.rect.x1 : '0;
    assign o_read_y_top    = is_read ? last.rect.y1 : '0;
    assign o_read_x_right  = is_read ? last.rect.x2 : '0;
    assign o_read_y_bottom = is_read ? last.rect.y2 : '0;
    assign o_read_always   = is_read && last.flag;
    assign o_read_used     = is_read && !rect_zero(last.rect);

endmodule
